@@ src/frm_pkg.sv @@
package frm_pkg;

    // Field widths
    localparam int COUNT_W    = 31;
    localparam int TIME_W     = 32;
    localparam int FPS_W      = 24;
    localparam int DIV_W      = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTING_ON    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLE_IS_SENDER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_FPS    = 2'd2;

    // Constants of the rate estimate
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [FPS_W-1:0]   FPS_MAX     = {FPS_W{1'b1}};
    localparam logic [FPS_W-1:0]   FPS_RESET   = 24'd15360;
    localparam logic [DIV_W-1:0]   MIN_MEAN_US = 32'd100;
    localparam logic [DIV_W-1:0]   RATE_SCALE  = 32'd256000000;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ src/frm_if.sv @@
interface frm_evt_if
    import frm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] observed_count;
    logic [TIME_W-1:0]  time_us;

    modport source (output valid, output observed_count, output time_us, input ready);
    modport sink (input valid, input observed_count, input time_us, output ready);
endinterface

interface frm_res_if
    import frm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               new_frame;
    logic [COUNT_W-1:0] frame_count;
    logic [FPS_W-1:0]   fps_estimate;

    modport source (output valid, output new_frame, output frame_count, output fps_estimate,
                    input ready);
    modport sink (input valid, input new_frame, input frame_count, input fps_estimate,
                  output ready);
endinterface

@@ src/frm_div.sv @@
module frm_div
    import frm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 run_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     dvs_reg;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;

    // One restoring step: shift in the next dividend bit, try the subtract
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            if (!diff[DIV_W])
            begin
                rem_reg <= diff[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ src/frame_rate_meter_unit.sv @@
// Channel  Dir  Handshake     Payload
// evt      in   valid/ready   observed_count[30:0], time_us[31:0]
// res      out  valid/ready   new_frame, frame_count[30:0], fps_estimate[23:0]
// cfg      in   cfg_we        cfg_index[1:0], cfg_data[23:0]
//
// One item at a time: accept, the evaluate state, then up to two passes of the
// shared 32-bit restoring divider, then the result.
// rst_n clears all control and estimate state at once; no clearing pass.
// evt.ready is high only while idle; a stalled result holds until res.ready.
module frame_rate_meter_unit
    import frm_pkg::*;
#(
    parameter int AVERAGE_LENGTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    frm_evt_if.sink               evt,
    frm_res_if.source             res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NUM_W = $clog2(AVERAGE_LENGTH + 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EVAL = 6'b000010,
        ST_PER  = 6'b000100,
        ST_MEAN = 6'b001000,
        ST_RATE = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t             state_reg,   state_next;
    logic               on_reg,      on_next;
    logic               sender_reg,  sender_next;
    logic [COUNT_W-1:0] obs_reg,     obs_next;
    logic [TIME_W-1:0]  time_reg,    time_next;
    logic [TIME_W-1:0]  prior_reg,   prior_next;
    logic [DIV_W-1:0]   sum_reg,     sum_next;
    logic [NUM_W-1:0]   num_reg,     num_next;
    logic [FPS_W-1:0]   fps_reg,     fps_next;
    logic [COUNT_W-1:0] cmp_reg,     cmp_next;
    logic [COUNT_W-1:0] cnt_reg,     cnt_next;
    logic               fresh_reg,   fresh_next;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic [TIME_W-1:0]  delta;
    logic [COUNT_W-1:0] gained;
    logic [DIV_W-1:0]   add_op;
    logic [DIV_W:0]     add_sum;
    logic [DIV_W-1:0]   sat_sum;
    logic [DIV_W+1:0]   damp_sum;
    logic [DIV_W-1:0]   damp_q;
    logic               add_frames;

    frm_div u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    // Interval and frames gained since the last counted frame
    assign delta  = time_reg - prior_reg;
    assign gained = sender_reg ? COUNT_W'(1) : obs_reg - cmp_reg;

    // Saturating interval accumulate
    assign add_op  = (state_reg == ST_PER) ? div_rsp.quotient : delta;
    assign add_sum = {1'b0, sum_reg} + {1'b0, add_op};
    assign sat_sum = add_sum[DIV_W] ? {DIV_W{1'b1}} : add_sum[DIV_W-1:0];

    // Damp: three quarters old plus one quarter new
    assign damp_sum = {{(DIV_W + 1 - FPS_W){1'b0}}, fps_reg, 1'b0}
                    + {{(DIV_W + 2 - FPS_W){1'b0}}, fps_reg}
                    + {2'b00, div_rsp.quotient};
    assign damp_q   = damp_sum[DIV_W+1:2];

    // Next state
    always_comb
    begin
        state_next  = state_reg;
        on_next     = on_reg;
        sender_next = sender_reg;
        obs_next    = obs_reg;
        time_next   = time_reg;
        prior_next  = prior_reg;
        sum_next    = sum_reg;
        num_next    = num_reg;
        fps_next    = fps_reg;
        cmp_next    = cmp_reg;
        cnt_next    = cnt_reg;
        fresh_next  = fresh_reg;
        add_frames  = 1'b0;
        div_req     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt.valid)
                begin
                    obs_next   = evt.observed_count;
                    time_next  = evt.time_us;
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                fresh_next = 1'b1;
                state_next = ST_OUT;
                if (on_reg)
                begin
                    if (sender_reg)
                    begin
                        if (cnt_reg != COUNT_MAX)
                        begin
                            cnt_next = cnt_reg + COUNT_W'(1);
                        end
                        add_frames = 1'b1;
                    end
                    else
                    begin
                        cnt_next = obs_reg;
                        if (obs_reg != '0)
                        begin
                            if (obs_reg == cmp_reg)
                            begin
                                fresh_next = 1'b0;
                            end
                            else
                            begin
                                add_frames = (obs_reg > cmp_reg);
                                cmp_next   = obs_reg;
                            end
                        end
                    end
                end

                // Count one interval or close the window
                if (add_frames)
                begin
                    prior_next = time_reg;
                    if (num_reg < NUM_W'(AVERAGE_LENGTH))
                    begin
                        if (gained != COUNT_W'(1))
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = delta;
                            div_req.divisor  = {{(DIV_W - COUNT_W){1'b0}}, gained};
                            state_next       = ST_PER;
                        end
                        else
                        begin
                            sum_next = sat_sum;
                            num_next = num_reg + NUM_W'(1);
                        end
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = sum_reg;
                        div_req.divisor  = {{(DIV_W - NUM_W){1'b0}}, num_reg};
                        sum_next         = '0;
                        num_next         = '0;
                        state_next       = ST_MEAN;
                    end
                end
            end

            ST_PER:
            begin
                if (div_rsp.done)
                begin
                    sum_next   = sat_sum;
                    num_next   = num_reg + NUM_W'(1);
                    state_next = ST_OUT;
                end
            end

            ST_MEAN:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient > MIN_MEAN_US)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = RATE_SCALE;
                        div_req.divisor  = div_rsp.quotient;
                        state_next       = ST_RATE;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end

            ST_RATE:
            begin
                if (div_rsp.done)
                begin
                    fps_next   = (|damp_q[DIV_W-1:FPS_W]) ? FPS_MAX : damp_q[FPS_W-1:0];
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (res.ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes must arrive only while idle; the block does not enforce it
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COUNTING_ON:    on_next     = cfg_data[0];
                CFG_ROLE_IS_SENDER: sender_next = cfg_data[0];
                CFG_INITIAL_FPS:    fps_next    = cfg_data[FPS_W-1:0];
                default:            ;
            endcase
        end
    end

    // Control and estimate state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            on_reg     <= 1'b0;
            sender_reg <= 1'b0;
            prior_reg  <= '0;
            sum_reg    <= '0;
            num_reg    <= '0;
            fps_reg    <= FPS_RESET;
            cmp_reg    <= '0;
            cnt_reg    <= '0;
            fresh_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            on_reg     <= on_next;
            sender_reg <= sender_next;
            prior_reg  <= prior_next;
            sum_reg    <= sum_next;
            num_reg    <= num_next;
            fps_reg    <= fps_next;
            cmp_reg    <= cmp_next;
            cnt_reg    <= cnt_next;
            fresh_reg  <= fresh_next;
        end
    end

    // Hold the accepted item
    always_ff @(posedge clk)
    begin
        obs_reg  <= obs_next;
        time_reg <= time_next;
    end

    assign evt.ready        = (state_reg == ST_IDLE);
    assign res.valid        = (state_reg == ST_OUT);
    assign res.new_frame    = fresh_reg;
    assign res.frame_count  = cnt_reg;
    assign res.fps_estimate = fps_reg;

endmodule

@@ bench/frame_rate_meter_checker.sv @@
module frame_rate_meter_checker
    import frm_pkg::*;
#(
    parameter int AVERAGE_LENGTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    frm_evt_if                    evt,
    frm_res_if                    res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    outstanding,
    output int                    checked
);

    typedef struct packed {
        logic               new_frame;
        logic [COUNT_W-1:0] frame_count;
        logic [FPS_W-1:0]   fps_estimate;
    } frame_report_t;

    // Expected reports, oldest first
    frame_report_t expected_reports[$];

    // Register copies
    logic               count_enable;
    logic               sender_role;

    // Estimator state
    logic [TIME_W-1:0]  last_frame_us;
    logic [31:0]        span_total;
    logic [4:0]         span_count;
    logic [FPS_W-1:0]   fps_q;
    logic [COUNT_W-1:0] last_seen_count;
    logic [COUNT_W-1:0] frame_total;

    int fails;
    int reports_done;

    initial
    begin
        fails = 0;
        reports_done = 0;
    end

    task automatic flag_mismatch(input string what);
        $display("checker: %s", what);
        fails++;
    endtask

    // Add the interval of the frames gained, or close the averaging window
    task automatic take_frames(input logic [TIME_W-1:0] now, input logic [COUNT_W-1:0] gained);
        logic [31:0] delta;
        logic [31:0] per_frame;
        logic [32:0] widened;
        logic [31:0] mean;
        logic [31:0] rate;
        logic [63:0] damped;
        delta = now - last_frame_us;
        last_frame_us = now;
        per_frame = (gained > 1) ? delta / {1'b0, gained} : delta;
        if (span_count < AVERAGE_LENGTH)
        begin
            widened = {1'b0, span_total} + {1'b0, per_frame};
            span_total = widened[32] ? 32'hFFFF_FFFF : widened[31:0];
            span_count = span_count + 5'd1;
        end
        else
        begin
            mean = (span_count != 0) ? span_total / {27'd0, span_count} : 32'd0;
            span_total = '0;
            span_count = '0;
            if (mean > MIN_MEAN_US)
            begin
                rate = RATE_SCALE / mean;
                damped = ({40'd0, fps_q} * 64'd3 + {32'd0, rate}) / 64'd4;
                fps_q = (damped > {40'd0, FPS_MAX}) ? FPS_MAX : damped[FPS_W-1:0];
            end
        end
    endtask

    // Work out the report for one accepted frame event
    task automatic predict_report(input logic [COUNT_W-1:0] observed,
                                  input logic [TIME_W-1:0] now);
        frame_report_t report;
        logic fresh;
        fresh = 1'b1;
        if (count_enable)
        begin
            if (sender_role)
            begin
                if (frame_total < COUNT_MAX)
                    frame_total = frame_total + 1'b1;
                take_frames(now, 31'd1);
            end
            else
            begin
                frame_total = observed;
                if (observed != 0)
                begin
                    if (observed == last_seen_count)
                        fresh = 1'b0;
                    else
                    begin
                        if (observed > last_seen_count)
                            take_frames(now, observed - last_seen_count);
                        last_seen_count = observed;
                    end
                end
            end
        end
        report.new_frame = fresh;
        report.frame_count = frame_total;
        report.fps_estimate = fps_q;
        expected_reports.push_back(report);
    endtask

    // Compare one delivered report against the oldest expectation
    task automatic compare_report();
        frame_report_t want;
        if (expected_reports.size() == 0)
        begin
            flag_mismatch($sformatf("report with nothing expected: new_frame %0d count %0d fps %0d",
                                    res.new_frame, res.frame_count, res.fps_estimate));
            return;
        end
        want = expected_reports.pop_front();
        reports_done++;
        if (res.new_frame !== want.new_frame)
            flag_mismatch($sformatf("report %0d new_frame: expected %0d got %0d",
                                    reports_done, want.new_frame, res.new_frame));
        if (res.frame_count !== want.frame_count)
            flag_mismatch($sformatf("report %0d frame_count: expected %0d got %0d",
                                    reports_done, want.frame_count, res.frame_count));
        if (res.fps_estimate !== want.fps_estimate)
            flag_mismatch($sformatf("report %0d fps_estimate: expected %0d got %0d",
                                    reports_done, want.fps_estimate, res.fps_estimate));
    endtask

    // Track register writes, accepted events and delivered reports
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_enable = 1'b0;
            sender_role = 1'b0;
            last_frame_us = '0;
            span_total = '0;
            span_count = '0;
            fps_q = FPS_RESET;
            last_seen_count = '0;
            frame_total = '0;
            expected_reports.delete();
            outstanding <= 0;
            fail_count <= fails;
            checked <= reports_done;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COUNTING_ON:    count_enable = cfg_data[0];
                    CFG_ROLE_IS_SENDER: sender_role = cfg_data[0];
                    CFG_INITIAL_FPS:    fps_q = cfg_data[FPS_W-1:0];
                    default: ;
                endcase
            end
            if (evt.valid && evt.ready)
                predict_report(evt.observed_count, evt.time_us);
            if (res.valid && res.ready)
                compare_report();
            fail_count <= fails;
            outstanding <= expected_reports.size();
            checked <= reports_done;
        end
    end

endmodule

@@ bench/frame_rate_meter_unit_tb.sv @@
module frame_rate_meter_unit_tb;
    import frm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT     = 2000000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int ITEM_TARGET     = 1600;
    localparam int DRAIN_CYCLES    = 100;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int outstanding;
    int checked;

    frm_evt_if evt();
    frm_res_if res();

    frame_rate_meter_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_rate_meter_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt         (evt),
        .res         (res),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked)
    );

    // Stimulus state
    int               items_sent = 0;
    int               settings_applied = 0;
    int               hold_cycles = 0;
    int               cycle_count = 0;
    bit               hold_req = 1'b0;
    bit               sink_idles = 1'b1;
    bit               source_idles = 1'b1;
    logic [COUNT_W-1:0] producer_count;
    logic [TIME_W-1:0]  clock_us;
    int               frame_period;
    int               phase_no;
    int               phase_items;
    int               roll;
    logic [TIME_W-1:0]  stamp;
    logic [COUNT_W-1:0] observed;
    logic [FPS_W-1:0]   fps_pick;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(30, 90);
    endfunction

    // Offer one frame event and hold it until accepted
    task automatic send_event(input logic [COUNT_W-1:0] count_in, input logic [TIME_W-1:0] t_in);
        int gap;
        gap = source_idles ? pick_gap() : 0;
        evt.valid <= 1'b1;
        evt.observed_count <= count_in;
        evt.time_us <= t_in;
        do
            @(posedge clk);
        while (!evt.ready);
        items_sent++;
        if (gap > 0)
        begin
            evt.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every report has come back
    task automatic wait_idle();
        evt.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Write a register setting in back-to-back cycles
    task automatic apply_settings(input bit counting, input bit sender, input bit load_fps,
                                  input logic [FPS_W-1:0] fps, input bit poke_spare);
        cfg_we <= 1'b1;
        cfg_index <= CFG_COUNTING_ON;
        cfg_data <= {23'd0, counting};
        @(posedge clk);
        cfg_index <= CFG_ROLE_IS_SENDER;
        cfg_data <= {23'd0, sender};
        @(posedge clk);
        if (load_fps)
        begin
            cfg_index <= CFG_INITIAL_FPS;
            cfg_data <= fps;
            @(posedge clk);
        end
        if (poke_spare)
        begin
            cfg_index <= CFG_SPARE;
            cfg_data <= 24'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Receiver side: random stalls, stretches of none, one long hold-off
    initial
    begin
        int gap_left;
        bit hold_done;
        gap_left = 0;
        hold_done = 1'b0;
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                res.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_cycles += HOLD_OFF_CYCLES;
                hold_done = 1'b1;
            end
            else if (!sink_idles)
                res.ready <= 1'b1;
            else if (gap_left > 0)
            begin
                res.ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                res.ready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                    gap_left = pick_gap();
            end
        end
    end

    // Cycle limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        rst_n <= 1'b0;
        evt.valid <= 1'b0;
        evt.observed_count <= '0;
        evt.time_us <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_COUNTING_ON;
        cfg_data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Counting off at reset: events pass through untouched
        send_event(COUNT_MAX, 32'hFFFF_FFFF);
        send_event('0, '0);
        wait_idle();

        // Receiver: zero count, several frames gained, repeat, drop, huge jump
        apply_settings(1'b1, 1'b0, 1'b1, FPS_MAX, 1'b1);
        send_event('0, 32'd1000);
        send_event(31'd5, 32'd2000);
        send_event(31'd5, 32'd3000);
        send_event(31'd3, 32'd4000);
        send_event(COUNT_MAX - 31'd1, 32'd5000);
        wait_idle();

        // Sender starting just below the top count: saturate
        apply_settings(1'b1, 1'b1, 1'b0, '0, 1'b0);
        send_event(31'($urandom), 32'd5060);
        send_event(31'($urandom), 32'd5120);
        wait_idle();

        // Sender with tiny intervals: the window closes on a short mean
        apply_settings(1'b1, 1'b1, 1'b1, '0, 1'b0);
        clock_us = 32'd5180;
        repeat (16)
        begin
            send_event(31'($urandom), clock_us);
            clock_us = clock_us + 32'd60;
        end
        wait_idle();

        // Random phases of well-formed frame streams with some noise
        producer_count = '0;
        phase_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 3))
                0:       fps_pick = '0;
                1:       fps_pick = FPS_MAX;
                2:       fps_pick = FPS_RESET;
                default: fps_pick = 24'($urandom);
            endcase
            apply_settings($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)),
                           $urandom_range(0, 2) == 0, fps_pick, $urandom_range(0, 7) == 0);
            case ($urandom_range(0, 5))
                0:       frame_period = 16667;
                1:       frame_period = 8333;
                2:       frame_period = 33333;
                3:       frame_period = $urandom_range(20, 150);
                4:       frame_period = $urandom_range(32'h1000_0000, 32'h3000_0000);
                default: frame_period = $urandom_range(1000, 100000);
            endcase
            sink_idles = ($urandom_range(0, 4) != 0);
            source_idles = ($urandom_range(0, 4) != 0);
            if (phase_no == 3)
            begin
                hold_req = 1'b1;
                source_idles = 1'b0;
            end
            phase_items = $urandom_range(40, 120);
            repeat (phase_items)
            begin
                // Timestamp: jittered frame period, sometimes anywhere
                if ($urandom_range(0, 99) < 5)
                    stamp = $urandom;
                else
                    stamp = clock_us + 32'(frame_period - frame_period / 8
                                           + int'($urandom_range(0, frame_period / 4)));
                clock_us = stamp;
                // Producer count: mostly next frame, some skips, repeats and breaks
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    producer_count = producer_count + 31'd1;
                else if (roll < 80)
                    producer_count = producer_count + 31'($urandom_range(2, 6));
                else if (roll < 88)
                    producer_count = producer_count;
                else if (roll < 91)
                    producer_count = '0;
                else if (roll < 94)
                    producer_count = producer_count - 31'($urandom_range(1, 20));
                else
                    producer_count = 31'($urandom);
                observed = producer_count;
                send_event(observed, stamp);
            end
            wait_idle();
            phase_no++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("tb: %0d frame events sent over %0d register settings, %0d reports checked",
                 items_sent, settings_applied, checked);
        $display("tb: both roles, counting off, count wrap and saturation, %0d hold-off cycles",
                 hold_cycles);
        if (fail_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
src/frm_pkg.sv
src/frm_if.sv
src/frm_div.sv
src/frame_rate_meter_unit.sv
bench/frame_rate_meter_checker.sv
bench/frame_rate_meter_unit_tb.sv
